[hw/rtl/jsu_pkg.sv]
`default_nettype none

package jsu_pkg;

    localparam int unsigned QUEUE_DEPTH = 4;

    // input request and result payloads
    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       done_res;
        logic [3:0] status;
        logic       last_of_run;
    } t_out;

    // one unit of work for the back end: up to four bytes or one end result
    typedef struct packed {
        logic [3:0][7:0] data;
        logic [1:0]      last_idx;
        logic            is_done;
        logic [3:0]      status;
    } t_job;

    localparam logic [3:0] ST_OK          = 4'd0;
    localparam logic [3:0] ST_TRUNC_ESC   = 4'd1;
    localparam logic [3:0] ST_TRUNC_U     = 4'd2;
    localparam logic [3:0] ST_BAD_HEX     = 4'd3;
    localparam logic [3:0] ST_NO_LOW      = 4'd4;
    localparam logic [3:0] ST_TRUNC_LOW   = 4'd5;
    localparam logic [3:0] ST_BAD_LOW_HEX = 4'd6;
    localparam logic [3:0] ST_NOT_LOW     = 4'd7;
    localparam logic [3:0] ST_LONE_LOW    = 4'd8;
    localparam logic [3:0] ST_BAD_ESC     = 4'd9;

    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_B         = 8'h62;
    localparam logic [7:0] CH_F         = 8'h66;
    localparam logic [7:0] CH_N         = 8'h6E;
    localparam logic [7:0] CH_R         = 8'h72;
    localparam logic [7:0] CH_T         = 8'h74;
    localparam logic [7:0] CH_U         = 8'h75;

    localparam logic [15:0] SURR_HI_FIRST = 16'hD800;
    localparam logic [15:0] SURR_HI_LAST  = 16'hDBFF;
    localparam logic [15:0] SURR_LO_FIRST = 16'hDC00;
    localparam logic [15:0] SURR_LO_LAST  = 16'hDFFF;
    localparam logic [20:0] SUPP_BASE     = 21'h10000;

    // bit 4 set means not a hex digit
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] d;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = {1'b0, c[3:0]};
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            d = {1'b0, c[3:0] + 4'd9};
        end else begin
            d = 5'h10;
        end
        return d;
    endfunction

    function automatic t_job utf8_job(input logic [20:0] cp);
        t_job j;
        j = '0;
        if (cp <= 21'h7F) begin
            j.data[0]  = cp[7:0];
            j.last_idx = 2'd0;
        end else if (cp <= 21'h7FF) begin
            j.data[0]  = {3'b110, cp[10:6]};
            j.data[1]  = {2'b10, cp[5:0]};
            j.last_idx = 2'd1;
        end else if (cp <= 21'hFFFF) begin
            j.data[0]  = {4'b1110, cp[15:12]};
            j.data[1]  = {2'b10, cp[11:6]};
            j.data[2]  = {2'b10, cp[5:0]};
            j.last_idx = 2'd2;
        end else begin
            j.data[0]  = {5'b11110, cp[20:18]};
            j.data[1]  = {2'b10, cp[17:12]};
            j.data[2]  = {2'b10, cp[11:6]};
            j.data[3]  = {2'b10, cp[5:0]};
            j.last_idx = 2'd3;
        end
        return j;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/jsu_front.sv]
`default_nettype none

module jsu_front
    import jsu_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_accept,
    input  t_in  i_item,
    output logic o_push,
    output t_job o_job
);

    localparam logic [2:0] MODE_PLAIN   = 3'd0;
    localparam logic [2:0] MODE_ESC     = 3'd1;
    localparam logic [2:0] MODE_HEX_HI  = 3'd2;
    localparam logic [2:0] MODE_WANT_BS = 3'd3;
    localparam logic [2:0] MODE_WANT_U  = 3'd4;
    localparam logic [2:0] MODE_HEX_LO  = 3'd5;

    logic [2:0]  r_mode,    n_mode;
    logic [1:0]  r_hex_cnt, n_hex_cnt;
    logic [15:0] r_hex_val, n_hex_val;
    logic [9:0]  r_high,    n_high;
    logic        r_bad,     n_bad;
    logic [3:0]  r_err,     n_err;

    logic [4:0]  digit;
    logic [15:0] hv;
    logic        bad_all;
    logic        fourth;
    logic [20:0] lo_cp;
    logic        job_ok;
    t_job        job;
    logic [7:0]  c;

    always_comb begin
        c         = i_item.data_byte;
        digit     = hex_digit(c);
        hv        = {r_hex_val[11:0], digit[4] ? 4'h0 : digit[3:0]};
        bad_all   = r_bad | digit[4];
        fourth    = (r_hex_cnt == 2'd3);
        lo_cp     = SUPP_BASE + {1'b0, r_high, hv[9:0]};

        n_mode    = r_mode;
        n_hex_cnt = r_hex_cnt;
        n_hex_val = r_hex_val;
        n_high    = r_high;
        n_bad     = r_bad;
        n_err     = r_err;
        job_ok    = 1'b0;
        job       = '0;

        if (i_item.kind) begin
            job.is_done = 1'b1;
            job.status  = r_err;
            if (r_err == ST_OK) begin
                unique case (r_mode) inside
                    MODE_ESC:     job.status = ST_TRUNC_ESC;
                    MODE_HEX_HI:  job.status = ST_TRUNC_U;
                    MODE_WANT_BS,
                    MODE_WANT_U:  job.status = ST_NO_LOW;
                    MODE_HEX_LO:  job.status = ST_TRUNC_LOW;
                    default:      job.status = ST_OK;
                endcase
            end
            job_ok    = 1'b1;
            n_mode    = MODE_PLAIN;
            n_hex_cnt = '0;
            n_hex_val = '0;
            n_high    = '0;
            n_bad     = 1'b0;
            n_err     = ST_OK;
        end else if (r_err == ST_OK) begin
            unique case (r_mode)
                MODE_ESC: begin
                    n_mode = MODE_PLAIN;
                    job_ok = 1'b1;
                    unique case (c)
                        CH_QUOTE:     job.data[0] = 8'h22;
                        CH_BACKSLASH: job.data[0] = 8'h5C;
                        CH_SLASH:     job.data[0] = 8'h2F;
                        CH_B:         job.data[0] = 8'h08;
                        CH_F:         job.data[0] = 8'h0C;
                        CH_N:         job.data[0] = 8'h0A;
                        CH_R:         job.data[0] = 8'h0D;
                        CH_T:         job.data[0] = 8'h09;
                        CH_U: begin
                            job_ok    = 1'b0;
                            n_mode    = MODE_HEX_HI;
                            n_hex_cnt = '0;
                            n_hex_val = '0;
                            n_bad     = 1'b0;
                        end
                        default: begin
                            job_ok = 1'b0;
                            n_mode = MODE_ESC;
                            n_err  = ST_BAD_ESC;
                        end
                    endcase
                end
                MODE_HEX_HI: begin
                    n_hex_val = hv;
                    n_bad     = bad_all;
                    n_hex_cnt = r_hex_cnt + 2'd1;
                    if (fourth) begin
                        if (bad_all) begin
                            n_err = ST_BAD_HEX;
                        end else if (hv >= SURR_LO_FIRST && hv <= SURR_LO_LAST) begin
                            n_err = ST_LONE_LOW;
                        end else if (hv >= SURR_HI_FIRST && hv <= SURR_HI_LAST) begin
                            // low 10 bits of the base are zero
                            n_high = hv[9:0];
                            n_mode = MODE_WANT_BS;
                        end else begin
                            n_mode = MODE_PLAIN;
                            job    = utf8_job({5'b0, hv});
                            job_ok = 1'b1;
                        end
                    end
                end
                MODE_WANT_BS: begin
                    if (c != CH_BACKSLASH) begin
                        n_err = ST_NO_LOW;
                    end else begin
                        n_mode = MODE_WANT_U;
                    end
                end
                MODE_WANT_U: begin
                    if (c != CH_U) begin
                        n_err = ST_NO_LOW;
                    end else begin
                        n_mode    = MODE_HEX_LO;
                        n_hex_cnt = '0;
                        n_hex_val = '0;
                        n_bad     = 1'b0;
                    end
                end
                MODE_HEX_LO: begin
                    n_hex_val = hv;
                    n_bad     = bad_all;
                    n_hex_cnt = r_hex_cnt + 2'd1;
                    if (fourth) begin
                        if (bad_all) begin
                            n_err = ST_BAD_LOW_HEX;
                        end else if (hv < SURR_LO_FIRST || hv > SURR_LO_LAST) begin
                            n_err = ST_NOT_LOW;
                        end else begin
                            n_mode = MODE_PLAIN;
                            job    = utf8_job(lo_cp);
                            job_ok = 1'b1;
                        end
                    end
                end
                default: begin
                    n_mode = MODE_PLAIN;
                    if (c == CH_BACKSLASH) begin
                        n_mode = MODE_ESC;
                    end else begin
                        job.data[0] = c;
                        job_ok      = 1'b1;
                    end
                end
            endcase
        end
    end

    assign o_push = i_accept & job_ok;
    assign o_job  = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_PLAIN;
            r_hex_cnt <= '0;
            r_hex_val <= '0;
            r_high    <= '0;
            r_bad     <= 1'b0;
            r_err     <= ST_OK;
        end else if (i_accept) begin
            r_mode    <= n_mode;
            r_hex_cnt <= n_hex_cnt;
            r_hex_val <= n_hex_val;
            r_high    <= n_high;
            r_bad     <= n_bad;
            r_err     <= n_err;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/jsu_fifo.sv]
`default_nettype none

module jsu_fifo
    import jsu_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH
) (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_push,
    input  t_job i_job,
    input  wire  i_pop,
    output t_job o_job,
    output logic o_valid,
    output logic o_full
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_job   = r_mem[r_rd_ptr];
    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == FULL_CNT);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

`default_nettype wire

[hw/rtl/jsu_back.sv]
`default_nettype none

module jsu_back
    import jsu_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  t_job i_job,
    input  wire  i_job_valid,
    output logic o_pop,
    output logic o_valid,
    input  wire  i_ready,
    output t_out o_result
);

    logic [1:0] r_idx;
    logic       r_out_valid;
    t_out       r_out;
    t_out       n_out;
    logic       load;
    logic       last;

    assign load = i_job_valid && (!r_out_valid || i_ready);
    assign last = (r_idx == i_job.last_idx);
    assign o_pop = load && last;

    always_comb begin
        n_out             = '0;
        n_out.last_of_run = last;
        if (i_job.is_done) begin
            n_out.done_res = 1'b1;
            n_out.status   = i_job.status;
        end else begin
            n_out.has_byte = 1'b1;
            n_out.out_byte = i_job.data[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
                r_idx       <= last ? 2'd0 : r_idx + 2'd1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

`default_nettype wire

[hw/rtl/json_string_unescape_utf8.sv]
// JSON string unescaper with UTF-8 output.
// Input channel (i_valid / o_ready / i_item): one request per string byte
// between the quotes, then one request with kind set to mark the end.
// Output channel (o_valid / i_ready / o_result): plain bytes and simple
// escapes give one result, a \uXXXX escape gives 1 to 3 results and a joined
// surrogate pair gives 4; escapes in progress and bytes after an error give
// none. The end request gives one result with done_res and the status.
// last_of_run marks the final result of each request.
// A request's first result enters the queue on acceptance, then the output
// register once that is free. Throughput: one request per cycle while the
// queue is not full; the output register sends one result per cycle while
// i_ready is high, so a request with n results takes n transfers. A queue
// of QDEPTH entries between the decoder and the output stage absorbs bursts;
// o_ready drops only when that queue is full. When the receiver stalls, the
// result holds in the output register and requests keep being taken until
// the queue fills. Reset clears the decoder state, queue and output valid.
`default_nettype none

module json_string_unescape_utf8
    import jsu_pkg::*;
#(
    parameter int unsigned QDEPTH = QUEUE_DEPTH
) (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_valid,
    output logic o_ready,
    input  t_in  i_item,
    output logic o_valid,
    input  wire  i_ready,
    output t_out o_result
);

    logic accept;
    logic push;
    t_job push_job;
    t_job head_job;
    logic head_valid;
    logic full;
    logic pop;

    assign o_ready = !full;
    assign accept  = i_valid && !full;

    jsu_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_item),
        .o_push   (push),
        .o_job    (push_job)
    );

    jsu_fifo #(
        .DEPTH (QDEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_valid (head_valid),
        .o_full  (full)
    );

    jsu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (head_job),
        .i_job_valid (head_valid),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_result    (o_result)
    );

endmodule

`default_nettype wire
